/* design/srlt_pkg.sv */
// Shared types, constants and step decode for the Salsa reduced-round linear test core.
package srlt_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned NumWords   = 16;
  localparam int unsigned KeyWidth   = 64;
  localparam int unsigned NumKeyRegs = 4;
  localparam int unsigned CfgIdxW    = $clog2(NumKeyRegs);
  localparam int unsigned CountWidth = 40;
  localparam int unsigned TotalWidth = 40;
  // Seven full rounds plus the first half of a row round, four steps per full round.
  localparam int unsigned CellCount  = 30;
  localparam int unsigned CellIdxW   = $clog2(CellCount);
  // Last step of the fifth round.
  localparam int unsigned SampleCell = 19;
  localparam int unsigned SampleWord = 4;
  localparam int unsigned SampleBit  = 7;

  typedef logic [WordWidth-1:0] word_t;
  typedef logic [NumWords-1:0][WordWidth-1:0] state_t;
  typedef logic [CountWidth-1:0] count_t;

  localparam word_t Sigma0 = 32'h6170_7865;
  localparam word_t Sigma1 = 32'h3320_646e;
  localparam word_t Sigma2 = 32'h7962_2d32;
  localparam word_t Sigma3 = 32'h6b20_6574;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_1_2   = 2'd0,
    REG_KEY_3_4   = 2'd1,
    REG_KEY_11_12 = 2'd2,
    REG_KEY_13_14 = 2'd3
  } cfg_reg_e;

  // Quarter-round step: which word of a, b, c, d is updated.
  typedef enum logic [1:0] {
    STEP_B = 2'd0,
    STEP_C = 2'd1,
    STEP_D = 2'd2,
    STEP_A = 2'd3
  } step_phase_e;

  localparam state_t MaskTable = {
    32'h0303_0080, 32'h0200_2080, 32'h0000_0000, 32'h0000_6001,
    32'h8000_0420, 32'h0180_0630, 32'h0100_0000, 32'h0008_4000,
    32'h8400_0000, 32'h0643_0000, 32'h0068_0000, 32'h0000_0080,
    32'h0002_0000, 32'h0000_2000, 32'h0000_0018, 32'h0000_0011
  };

  typedef struct packed {
    logic        row;
    step_phase_e phase;
    logic        sample;
  } step_cfg_t;

  typedef struct packed {
    state_t state;
    logic   restart;
    logic   early;
  } cell_data_t;

  typedef struct packed {
    word_t nonce_word_six;
    word_t nonce_word_seven;
    word_t nonce_word_eight;
    word_t nonce_word_nine;
    logic  restart;
  } in_item_t;

  typedef struct packed {
    logic                  early_bit;
    logic                  mask_parity;
    logic                  agree;
    logic [TotalWidth-1:0] agreement_total;
  } out_item_t;

  // Word index of quarter q, role pos (0=a, 1=b, 2=c, 3=d) in a column or row round.
  function automatic logic [3:0] qr_word(input logic row, input logic [1:0] pos,
                                         input logic [1:0] q);
    logic [1:0] lane;
    lane = q + pos;
    if (row) begin
      return {q, lane};
    end
    return {q, q} + {pos, 2'b00};
  endfunction

  function automatic word_t step_rotl(input word_t v, input step_phase_e phase);
    word_t r;
    unique case (phase)
      STEP_B:  r = {v[24:0], v[31:25]};
      STEP_C:  r = {v[22:0], v[31:23]};
      STEP_D:  r = {v[18:0], v[31:19]};
      STEP_A:  r = {v[13:0], v[31:14]};
      default: r = v;
    endcase
    return r;
  endfunction

  function automatic step_cfg_t cell_step(input logic [CellIdxW-1:0] k);
    step_cfg_t c;
    c.row    = k[2];
    c.phase  = step_phase_e'(k[1:0]);
    c.sample = (k == CellIdxW'(SampleCell));
    return c;
  endfunction

endpackage

/* design/srlt_channels.sv */
// Valid/ready channel interfaces for input and result items.
interface srlt_in_if;
  logic               valid;
  logic               ready;
  srlt_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface srlt_out_if;
  logic                valid;
  logic                ready;
  srlt_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* design/srlt_cell.sv */
// One quarter-round step across all four quarters, registered.
module srlt_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  srlt_pkg::step_cfg_t    step_i,
  input  logic                   valid_i,
  input  srlt_pkg::cell_data_t   data_i,
  output logic                   valid_o,
  output srlt_pkg::cell_data_t   data_o
);

  logic                 valid_q;
  srlt_pkg::cell_data_t data_q, data_d;

  always_comb begin
    logic [3:0]      t;
    logic [3:0]      x;
    logic [3:0]      y;
    srlt_pkg::word_t sum;
    data_d = data_i;
    for (int q = 0; q < 4; q++) begin
      t = srlt_pkg::qr_word(step_i.row, 2'(step_i.phase) + 2'd1, 2'(q));
      x = srlt_pkg::qr_word(step_i.row, 2'(step_i.phase), 2'(q));
      y = srlt_pkg::qr_word(step_i.row, 2'(step_i.phase) + 2'd3, 2'(q));
      sum = data_i.state[x] + data_i.state[y];
      data_d.state[t] = data_i.state[t] ^ srlt_pkg::step_rotl(sum, step_i.phase);
    end
    if (step_i.sample) begin
      data_d.early = data_d.state[srlt_pkg::SampleWord][srlt_pkg::SampleBit];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* design/srlt_tail.sv */
// Mask parity stage followed by the agreement counter and result register.
module srlt_tail (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  valid_i,
  input  srlt_pkg::cell_data_t  data_i,
  output logic                  valid_o,
  output srlt_pkg::out_item_t   item_o
);

  logic                par_valid_q;
  logic                par_q;
  logic                early_q;
  logic                restart_q;
  logic                out_valid_q;
  srlt_pkg::out_item_t item_q, item_d;
  srlt_pkg::count_t    count_q, count_d;
  srlt_pkg::count_t    count_base;
  logic                agree;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_valid_q <= 1'b0;
    end else if (adv_i) begin
      par_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      par_q     <= ^(data_i.state & srlt_pkg::MaskTable);
      early_q   <= data_i.early;
      restart_q <= data_i.restart;
    end
  end

  always_comb begin
    agree      = (early_q == par_q);
    count_base = restart_q ? '0 : count_q;
    // hold at the maximum
    if (agree && !(&count_base)) begin
      count_d = count_base + srlt_pkg::CountWidth'(1);
    end else begin
      count_d = count_base;
    end
    item_d.early_bit       = early_q;
    item_d.mask_parity     = par_q;
    item_d.agree           = agree;
    item_d.agreement_total = srlt_pkg::TotalWidth'(64'(count_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else if (adv_i) begin
      out_valid_q <= par_valid_q;
      if (par_valid_q) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && par_valid_q) begin
      item_q <= item_d;
    end
  end

  assign valid_o = out_valid_q;
  assign item_o  = item_q;

endmodule

/* design/salsa_reduced_round_linear_test_core.sv */
// An accepted item passes through 30 step cells, a parity stage and the result register
// before it appears as the result item on out_o.
// Throughput: one item per cycle when not stalled; each cell does one quarter-round
// step of all four quarters, so the chain of 30 cells holds 30 items in flight.
// A stalled result freezes the whole chain and the input is held off that cycle.
// Reset clears all valid bits, the key registers and the agreement count.
module salsa_reduced_round_linear_test_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [srlt_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [srlt_pkg::KeyWidth-1:0]       cfg_wdata_i,
  srlt_in_if.sink                             in_i,
  srlt_out_if.source                          out_o
);

  localparam int unsigned N = srlt_pkg::CellCount;

  logic [srlt_pkg::KeyWidth-1:0] key_q [srlt_pkg::NumKeyRegs];
  logic                          adv;
  logic                          tail_valid;
  logic [N:0]                    cell_valid;
  srlt_pkg::cell_data_t          cell_data [N+1];
  srlt_pkg::cell_data_t          head_data;
  srlt_pkg::out_item_t           tail_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < srlt_pkg::NumKeyRegs; i++) begin
        key_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      key_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // advance the chain unless a result waits for the sink
  assign adv      = !tail_valid || out_o.ready;
  assign in_i.ready = adv;

  always_comb begin
    head_data.restart      = in_i.payload.restart;
    head_data.early        = 1'b0;
    head_data.state[0]     = srlt_pkg::Sigma0;
    head_data.state[1]     = key_q[srlt_pkg::REG_KEY_1_2][31:0];
    head_data.state[2]     = key_q[srlt_pkg::REG_KEY_1_2][63:32];
    head_data.state[3]     = key_q[srlt_pkg::REG_KEY_3_4][31:0];
    head_data.state[4]     = key_q[srlt_pkg::REG_KEY_3_4][63:32];
    head_data.state[5]     = srlt_pkg::Sigma1;
    head_data.state[6]     = in_i.payload.nonce_word_six;
    head_data.state[7]     = in_i.payload.nonce_word_seven;
    head_data.state[8]     = in_i.payload.nonce_word_eight;
    head_data.state[9]     = in_i.payload.nonce_word_nine;
    head_data.state[10]    = srlt_pkg::Sigma2;
    head_data.state[11]    = key_q[srlt_pkg::REG_KEY_11_12][31:0];
    head_data.state[12]    = key_q[srlt_pkg::REG_KEY_11_12][63:32];
    head_data.state[13]    = key_q[srlt_pkg::REG_KEY_13_14][31:0];
    head_data.state[14]    = key_q[srlt_pkg::REG_KEY_13_14][63:32];
    head_data.state[15]    = srlt_pkg::Sigma3;
  end

  assign cell_valid[0] = in_i.valid;
  assign cell_data[0]  = head_data;

  for (genvar g = 0; g < N; g++) begin : g_cell
    srlt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .step_i  (srlt_pkg::cell_step(srlt_pkg::CellIdxW'(g))),
      .valid_i (cell_valid[g]),
      .data_i  (cell_data[g]),
      .valid_o (cell_valid[g+1]),
      .data_o  (cell_data[g+1])
    );
  end

  srlt_tail u_tail (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (cell_valid[N]),
    .data_i  (cell_data[N]),
    .valid_o (tail_valid),
    .item_o  (tail_item)
  );

  assign out_o.valid   = tail_valid;
  assign out_o.payload = tail_item;

`ifndef SYNTHESIS
  a_stall_freezes_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(cell_valid[N:1]))
    else $error("step chain moved while the result was stalled");

  a_accept_enters_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> cell_valid[1])
    else $error("accepted item missing from the first cell");

  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_valid && !out_o.ready) |=> (tail_valid && $stable(tail_item)))
    else $error("stalled result changed");
`endif

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the Salsa reduced-round linear test core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import srlt_pkg::*;

  typedef word_t salsa_words_t [NumWords];

  localparam count_t AgreeCountMax = {CountWidth{1'b1}};
  localparam int unsigned DrainCycles = 40;

  // Linear mask applied to the state after seven and a half rounds.
  localparam word_t LinearMask [NumWords] = '{
    32'h0000_0011, 32'h0000_0018, 32'h0000_2000, 32'h0002_0000,
    32'h0000_0080, 32'h0068_0000, 32'h0643_0000, 32'h8400_0000,
    32'h0008_4000, 32'h0100_0000, 32'h0180_0630, 32'h8000_0420,
    32'h0000_6001, 32'h0000_0000, 32'h0200_2080, 32'h0303_0080
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [KeyWidth-1:0] cfg_wdata_i;

  srlt_in_if  in_if ();
  srlt_out_if out_if ();

  salsa_reduced_round_linear_test_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state: key registers and agreement count as the block should hold them.
  logic [KeyWidth-1:0] key_model [NumKeyRegs];
  count_t agree_count;

  in_item_t  nonce_q [$];
  out_item_t result_q [$];
  int unsigned queued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned mismatch_cnt = 0;

  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  logic hold_sink = 1'b0;

  // Sender and receiver pacing.
  logic src_busy = 1'b0;
  logic src_quiet = 1'b0;
  int unsigned src_gap = 0;
  logic snk_quiet = 1'b0;
  int unsigned snk_stall = 0;

  logic [1:0] probe;
  out_item_t want;
  out_item_t got;

  function automatic word_t rol_word(word_t v, int unsigned r);
    return (v << r) | (v >> (WordWidth - r));
  endfunction

  // One column or row round; a half round does only the b and c updates.
  function automatic salsa_words_t apply_round(salsa_words_t s, bit row, bit full);
    int a, b, c, d, q;
    for (q = 0; q < 4; q++) begin
      a = 5 * q;
      if (row) begin
        b = 4 * q + (q + 1) % 4;
        c = 4 * q + (q + 2) % 4;
        d = 4 * q + (q + 3) % 4;
      end else begin
        b = (a + 4) % 16;
        c = (a + 8) % 16;
        d = (a + 12) % 16;
      end
      s[b] ^= rol_word(s[a] + s[d], 7);
      s[c] ^= rol_word(s[b] + s[a], 9);
      if (full) begin
        s[d] ^= rol_word(s[c] + s[b], 13);
        s[a] ^= rol_word(s[d] + s[c], 18);
      end
    end
    return s;
  endfunction

  // Returns {early bit, mask parity} for one nonce under the current key.
  function automatic logic [1:0] salsa_probe(in_item_t it);
    salsa_words_t s;
    word_t acc;
    logic early;
    int i;
    s[0]  = 32'h6170_7865;
    s[5]  = 32'h3320_646e;
    s[10] = 32'h7962_2d32;
    s[15] = 32'h6b20_6574;
    s[1]  = key_model[REG_KEY_1_2][31:0];
    s[2]  = key_model[REG_KEY_1_2][63:32];
    s[3]  = key_model[REG_KEY_3_4][31:0];
    s[4]  = key_model[REG_KEY_3_4][63:32];
    s[11] = key_model[REG_KEY_11_12][31:0];
    s[12] = key_model[REG_KEY_11_12][63:32];
    s[13] = key_model[REG_KEY_13_14][31:0];
    s[14] = key_model[REG_KEY_13_14][63:32];
    s[6]  = it.nonce_word_six;
    s[7]  = it.nonce_word_seven;
    s[8]  = it.nonce_word_eight;
    s[9]  = it.nonce_word_nine;
    s = apply_round(s, 1'b0, 1'b1);
    s = apply_round(s, 1'b1, 1'b1);
    s = apply_round(s, 1'b0, 1'b1);
    s = apply_round(s, 1'b1, 1'b1);
    s = apply_round(s, 1'b0, 1'b1);
    early = s[4][7];
    s = apply_round(s, 1'b1, 1'b1);
    s = apply_round(s, 1'b0, 1'b1);
    s = apply_round(s, 1'b1, 1'b0);
    acc = '0;
    for (i = 0; i < NumWords; i++) begin
      acc ^= s[i] & LinearMask[i];
    end
    return {early, ^acc};
  endfunction

  task automatic check_field(string name, logic [63:0] w, logic [63:0] g);
    if (w !== g) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) begin
        $display("%0t: %s mismatch: expected %0h actual %0h", $realtime, name, w, g);
      end
    end
  endtask

  // Predict on input accept, compare on result accept.
  always @(posedge clk_i) begin
    in_fire  <= in_if.valid && in_if.ready;
    out_fire <= out_if.valid && out_if.ready;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        probe = salsa_probe(in_if.payload);
        if (in_if.payload.restart) begin
          agree_count = '0;
        end
        if ((probe[1] == probe[0]) && (agree_count != AgreeCountMax)) begin
          agree_count++;
        end
        want.early_bit       = probe[1];
        want.mask_parity     = probe[0];
        want.agree           = (probe[1] == probe[0]);
        want.agreement_total = agree_count[TotalWidth-1:0];
        result_q.push_back(want);
        accepted_cnt++;
      end
      if (out_if.valid && out_if.ready) begin
        got = out_if.payload;
        if (result_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: result item with none expected: %0h", $realtime, got);
          end
        end else begin
          want = result_q.pop_front();
          check_field("early_bit", want.early_bit, got.early_bit);
          check_field("mask_parity", want.mask_parity, got.mask_parity);
          check_field("agree", want.agree, got.agree);
          check_field("agreement_total", want.agreement_total, got.agreement_total);
        end
      end
    end
  end

  // Sender: offer queued nonces, with a random gap before each new item.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      src_busy = 1'b0;
    end else begin
      if (src_busy && in_fire) begin
        src_busy = 1'b0;
        if ($urandom_range(0, 39) == 0) begin
          src_quiet = ~src_quiet;
        end
        src_gap = src_quiet ? 0 : $urandom_range(0, 11);
      end
      if (!src_busy) begin
        if (src_gap > 0) begin
          src_gap--;
          in_if.valid <= 1'b0;
        end else if (nonce_q.size() > 0) begin
          in_if.payload <= nonce_q.pop_front();
          in_if.valid   <= 1'b1;
          src_busy = 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall a random number of cycles after each result item.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_fire) begin
        if ($urandom_range(0, 39) == 0) begin
          snk_quiet = ~snk_quiet;
        end
        snk_stall = snk_quiet ? 0 : $urandom_range(0, 11);
      end
      if (hold_sink) begin
        out_if.ready <= 1'b0;
      end else if (snk_stall > 0) begin
        snk_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off in mid run so the pipeline fills and backs up the input.
  initial begin
    while (accepted_cnt < 600) @(posedge clk_i);
    @(negedge clk_i);
    hold_sink <= 1'b1;
    repeat (150) @(negedge clk_i);
    hold_sink <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic push_nonce(word_t w6, word_t w7, word_t w8, word_t w9, logic restart);
    in_item_t it;
    it.nonce_word_six   = w6;
    it.nonce_word_seven = w7;
    it.nonce_word_eight = w8;
    it.nonce_word_nine  = w9;
    it.restart          = restart;
    nonce_q.push_back(it);
    queued_cnt++;
  endtask

  task automatic write_key(cfg_reg_e idx, logic [KeyWidth-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    key_model[idx] = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all_keys(logic [KeyWidth-1:0] k0, logic [KeyWidth-1:0] k1,
                                logic [KeyWidth-1:0] k2, logic [KeyWidth-1:0] k3);
    write_key(REG_KEY_1_2, k0);
    write_key(REG_KEY_3_4, k1);
    write_key(REG_KEY_11_12, k2);
    write_key(REG_KEY_13_14, k3);
    @(posedge clk_i);
  endtask

  // Wait for every queued item to be accepted and answered, then let the pipe drain.
  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || result_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [KeyWidth-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  initial begin
    int p, n;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_KEY_1_2;
    cfg_wdata_i   = '0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    out_if.ready  = 1'b0;
    for (p = 0; p < NumKeyRegs; p++) begin
      key_model[p] = '0;
    end
    agree_count = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset key, field extremes and restarts.
    push_nonce('0, '0, '0, '0, 1'b0);
    push_nonce('1, '1, '1, '1, 1'b0);
    push_nonce(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 1'b0);
    push_nonce(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 1'b0);
    push_nonce(32'h0000_0001, 32'h8000_0000, 32'h0000_0080, 32'h0100_0000, 1'b0);
    push_nonce(32'h8000_0000, 32'h0000_0001, 32'h0008_4000, 32'h0643_0000, 1'b1);
    push_nonce(32'd0, 32'd1, 32'd2, 32'd3, 1'b1);
    push_nonce('1, '0, '1, '0, 1'b1);
    push_nonce('0, '1, '0, '1, 1'b0);
    push_nonce(32'd4, 32'd5, 32'd6, 32'd7, 1'b0);
    push_nonce(32'hffff_fffe, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff, 1'b1);
    push_nonce(32'h1234_5678, 32'h9abc_def0, 32'h0fed_cba9, 32'h8765_4321, 1'b0);
    wait_drained();

    write_all_keys('1, '1, '1, '1);
    push_nonce('0, '0, '0, '0, 1'b1);
    push_nonce('1, '1, '1, '1, 1'b0);
    push_nonce(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 1'b0);
    push_nonce(32'd0, 32'd1, 32'd2, 32'd3, 1'b1);
    push_nonce(32'hdead_beef, 32'h0000_ffff, 32'hffff_0000, 32'h0f0f_0f0f, 1'b0);
    push_nonce('1, '0, '0, '1, 1'b1);
    push_nonce(32'h0000_0080, 32'h0000_0080, 32'h0000_0080, 32'h0000_0080, 1'b0);
    push_nonce(32'h8000_0001, 32'h8000_0001, 32'h8000_0001, 32'h8000_0001, 1'b0);
    wait_drained();

    // Random nonces under a series of key settings.
    for (p = 0; p < 6; p++) begin
      case (p)
        0: write_all_keys('0, '0, '0, '0);
        1: write_all_keys('1, '1, '1, '1);
        2: write_all_keys({2{32'haaaa_aaaa}}, {2{32'h5555_5555}},
                          {2{32'h5555_5555}}, {2{32'haaaa_aaaa}});
        default: write_all_keys(rand_key(), rand_key(), rand_key(), rand_key());
      endcase
      for (n = 0; n < 275; n++) begin
        push_nonce($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 15) == 0);
      end
      wait_drained();
    end

    if (mismatch_cnt == 0 && result_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/srlt_pkg.sv
design/srlt_channels.sv
design/srlt_cell.sv
design/srlt_tail.sv
design/salsa_reduced_round_linear_test_core.sv
dv/testbench.sv
